FILE: src/mvcm_pkg.sv
package mvcm_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int VOICE_INPUTS = 4;

  localparam int FADE_LENGTH = 480;
  localparam int FADE_SHIFT = 26;
  localparam logic [26:0] FADE_RECIP = 27'((64'd1 << FADE_SHIFT) / FADE_LENGTH);

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [31:0] NOISE_SEED = 32'h0001_2345;
  localparam logic signed [15:0] NOISE_OFFSET = 16'sd16383;

  localparam logic [15:0] MASTER_GAIN_RESET = 16'd4096;
  localparam logic [1:0] CHANNEL_COUNT_RESET = 2'd2;
  localparam logic [11:0] TRIGGER_LENGTH_RESET = 12'd2400;

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_MASTER_GAIN = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_TRIGGER_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_MIX   = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_MG,
    S_ACC,
    S_LCG,
    S_NOISE,
    S_FMUL,
    S_FQ,
    S_FCOR,
    S_TRIG,
    S_OUT
  } state_t;

endpackage

FILE: src/multi_voice_capture_mixer_core.sv
// Channel   Handshake                 Beat contents
// config    psel/penable/pwrite       master_gain, channel_count, trigger_length
// in        in_valid / in_ready       opcode, slot, gain, length, voice and capture samples
// out       out_valid / out_ready     mixed_left, mixed_right, active_mask, was_mixed
//
// All products come from one shared 33x33 multiplier. Start, stop and nop go straight
// to the result. A mix visits each slot: idle slots are skipped, playing ones are scaled
// by gain and master_gain and summed, plus noise while triggered, faded below FADE_LENGTH.
// Reset is synchronous; it restores register defaults, idles every slot, reseeds noise.
// in_ready is high only between items; a result held by out_ready stalls the next one.
module multi_voice_capture_mixer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mvcm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [1:0]                    slot,
  input  logic [15:0]                   gain_setting,
  input  logic [23:0]                   sound_length,
  input  logic signed [15:0]            voice_sample_0,
  input  logic signed [15:0]            voice_sample_1,
  input  logic signed [15:0]            voice_sample_2,
  input  logic signed [15:0]            voice_sample_3,
  input  logic signed [15:0]            capture_left,
  input  logic signed [15:0]            capture_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            mixed_left,
  output logic signed [15:0]            mixed_right,
  output logic [3:0]                    active_mask,
  output logic                          was_mixed
);
  import mvcm_pkg::*;

  logic [15:0] master_gain;
  logic [1:0]  channel_count;
  logic [11:0] trigger_length;

  logic [23:0] slot_remaining [NUM_SLOTS];
  logic [15:0] slot_gain [NUM_SLOTS];
  logic [11:0] slot_trigger_left [NUM_SLOTS];
  logic [31:0] noise_state;

  state_t state, state_next;
  opcode_t op;
  logic [SLOT_W-1:0] slot_idx;
  logic signed [15:0] voice [VOICE_INPUTS];
  logic signed [15:0] cap_l, cap_r;
  logic signed [31:0] mix;
  logic any;
  logic [25:0] fade_x;
  logic [14:0] fade_q;
  logic noise_neg;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic cfg_write, in_fire, out_free, last, advance;
  logic signed [15:0] smp;
  logic signed [15:0] noise;
  logic [14:0] noise_mag;
  logic signed [65:0] p_adj;
  logic signed [31:0] slot_term;
  logic [25:0] fade_rem;
  logic [14:0] fade_quot;
  logic [23:0] rem_cur;
  logic [11:0] trig_cur;
  logic [3:0] mask_now;
  logic trig_ok;

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    if (v > 33'sd32767) begin
      return 16'sh7fff;
    end else if (v < -33'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain <= MASTER_GAIN_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
      trigger_length <= TRIGGER_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_MASTER_GAIN: master_gain <= pwdata[15:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[1:0];
        REG_TRIGGER_LENGTH: trigger_length <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MASTER_GAIN: prdata = {16'd0, master_gain};
      REG_CHANNEL_COUNT: prdata = {30'd0, channel_count};
      REG_TRIGGER_LENGTH: prdata = {20'd0, trigger_length};
      default: prdata = 32'd0;
    endcase
  end

  always_comb begin
    smp = 16'sd0;
    for (int i = 0; i < VOICE_INPUTS; i++) begin
      if (i < NUM_SLOTS && int'(slot_idx) == i) begin
        smp = voice[i];
      end
    end
  end

  assign rem_cur = slot_remaining[slot_idx];
  assign trig_cur = slot_trigger_left[slot_idx];
  assign last = (int'(slot_idx) == NUM_SLOTS - 1);
  assign noise = $signed({1'b0, noise_state[30:16]}) - NOISE_OFFSET;
  assign noise_mag = noise[15] ? 15'(-noise) : noise[14:0];
  assign p_adj = mul_p + (mul_p[65] ? 66'sd4194303 : 66'sd0);
  assign slot_term = p_adj[53:22];
  assign fade_rem = fade_x - mul_p[25:0];
  assign fade_quot = fade_q + 15'(fade_rem >= 26'(FADE_LENGTH));

  assign advance = (state == S_SLOT && rem_cur == 24'd0)
                || (state == S_ACC && trig_cur == 12'd0)
                || (state == S_TRIG);

  always_comb begin
    mask_now = 4'd0;
    for (int s = 0; s < NUM_SLOTS && s < 4; s++) begin
      mask_now[s] = (slot_remaining[s] != 24'd0);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (opcode_t'(opcode) == OP_MIX) ? S_SLOT : S_OUT;
        end
      end
      S_SLOT: begin
        if (rem_cur == 24'd0) begin
          state_next = last ? S_OUT : S_SLOT;
        end else begin
          state_next = S_MG;
        end
      end
      S_MG: state_next = S_ACC;
      S_ACC: begin
        if (trig_cur != 12'd0) begin
          state_next = S_LCG;
        end else begin
          state_next = last ? S_OUT : S_SLOT;
        end
      end
      S_LCG: state_next = S_NOISE;
      S_NOISE: state_next = (trig_cur < 12'(FADE_LENGTH)) ? S_FMUL : S_TRIG;
      S_FMUL: state_next = S_FQ;
      S_FQ: state_next = S_FCOR;
      S_FCOR: state_next = S_TRIG;
      S_TRIG: state_next = last ? S_OUT : S_SLOT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    unique case (state)
      S_SLOT: begin
        mul_a = 33'(smp);
        mul_b = $signed({17'd0, slot_gain[slot_idx]});
      end
      S_MG: begin
        mul_a = mul_p[32:0];
        mul_b = $signed({17'd0, master_gain});
      end
      S_ACC: begin
        mul_a = $signed({1'b0, noise_state});
        mul_b = $signed({1'b0, LCG_MUL});
      end
      S_NOISE: begin
        mul_a = $signed({18'd0, noise_mag});
        mul_b = $signed({21'd0, trig_cur});
      end
      S_FMUL: begin
        mul_a = $signed({7'd0, mul_p[25:0]});
        mul_b = $signed({6'd0, FADE_RECIP});
      end
      S_FQ: begin
        mul_a = $signed({18'd0, mul_p[40:26]});
        mul_b = 33'(FADE_LENGTH);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      noise_state <= NOISE_SEED;
      slot_idx <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_remaining[s] <= 24'd0;
        slot_gain[s] <= 16'd0;
        slot_trigger_left[s] <= 12'd0;
      end
    end else begin
      state <= state_next;
      if (in_fire) begin
        slot_idx <= '0;
        unique case (opcode_t'(opcode))
          OP_START: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
              if (int'(slot) == s && sound_length != 24'd0) begin
                slot_remaining[s] <= sound_length;
                slot_gain[s] <= gain_setting;
                slot_trigger_left[s] <= trigger_length;
              end
            end
          end
          OP_STOP: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
              slot_remaining[s] <= 24'd0;
              slot_trigger_left[s] <= 12'd0;
            end
          end
          default: ;
        endcase
      end
      if (advance && !last) begin
        slot_idx <= slot_idx + 1'b1;
      end
      if (state == S_ACC) begin
        slot_remaining[slot_idx] <= rem_cur - 24'd1;
      end
      if (state == S_LCG) begin
        noise_state <= mul_p[31:0] + LCG_ADD;
      end
      if (state == S_TRIG) begin
        slot_trigger_left[slot_idx] <= (rem_cur == 24'd0) ? 12'd0 : trig_cur - 12'd1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op <= opcode_t'(opcode);
      cap_l <= capture_left;
      cap_r <= capture_right;
      voice[0] <= voice_sample_0;
      voice[1] <= voice_sample_1;
      voice[2] <= voice_sample_2;
      voice[3] <= voice_sample_3;
      mix <= 32'sd0;
      any <= 1'b0;
    end
    if (state == S_SLOT && rem_cur != 24'd0) begin
      any <= 1'b1;
    end
    if (state == S_ACC) begin
      mix <= mix + slot_term;
    end
    if (state == S_NOISE) begin
      noise_neg <= noise[15];
      if (trig_cur >= 12'(FADE_LENGTH)) begin
        mix <= mix + 32'(noise);
      end
    end
    if (state == S_FMUL) begin
      fade_x <= mul_p[25:0];
    end
    if (state == S_FQ) begin
      fade_q <= mul_p[40:26];
    end
    if (state == S_FCOR) begin
      mix <= noise_neg ? mix - $signed({17'd0, fade_quot})
                       : mix + $signed({17'd0, fade_quot});
    end
    if (state == S_OUT && out_free) begin
      mixed_left <= (op == OP_MIX && any && channel_count >= 2'd1)
                  ? sat16(33'(cap_l) + 33'(mix)) : cap_l;
      mixed_right <= (op == OP_MIX && any && channel_count >= 2'd2)
                   ? sat16(33'(cap_r) + 33'(mix)) : cap_r;
      was_mixed <= (op == OP_MIX) && any;
      active_mask <= mask_now;
    end
  end

  always_comb begin
    trig_ok = 1'b1;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (slot_trigger_left[s] != 12'd0 && slot_remaining[s] == 24'd0) begin
        trig_ok = 1'b0;
      end
    end
  end

  a_trigger_needs_sound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> trig_ok)
    else $error("trigger count left on an idle slot");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT))
    else $error("result loaded over a pending beat");

  a_fade_one_fix: assert property (@(posedge clk) disable iff (rst)
    (state == S_FCOR) |-> (fade_rem < 26'(2 * FADE_LENGTH)))
    else $error("fade quotient estimate off by more than one");

  a_last_slot_done: assert property (@(posedge clk) disable iff (rst)
    (advance && last) |=> (state == S_OUT))
    else $error("slot walk did not finish after last slot");

endmodule
